// ===== hw/rtl/gfba_pkg.sv =====
// gfba_pkg: shared constants and codes of the grouped free block allocator
`default_nettype none

package gfba_pkg;

   localparam int GROUP_DEF      = 32;
   localparam int BLOCK_BITS_DEF = 24;
   localparam int KIND_W         = 2;
   localparam int RESULT_W       = 3;

   localparam logic [KIND_W-1:0] KIND_FREE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REFILL = 2'd2;

   localparam logic [RESULT_W-1:0] RES_FREED   = 3'd0;
   localparam logic [RESULT_W-1:0] RES_GRANTED = 3'd1;
   localparam logic [RESULT_W-1:0] RES_NONE    = 3'd2;
   localparam logic [RESULT_W-1:0] RES_SPILL   = 3'd3;
   localparam logic [RESULT_W-1:0] RES_REFILL  = 3'd4;
   localparam logic [RESULT_W-1:0] RES_REFUSED = 3'd5;

endpackage

`default_nettype wire

// ===== hw/rtl/gfba_req_if.sv =====
// gfba_req_if: request channel with valid/ready handshake
`default_nettype none

interface gfba_req_if
   import gfba_pkg::*;
#(
   parameter int BLOCK_BITS = BLOCK_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [KIND_W-1:0]     kind;
   logic [BLOCK_BITS-1:0] block_number;
   logic [BLOCK_BITS-1:0] refill_word;

   modport source (output valid, output kind, output block_number, output refill_word,
                   input ready);
   modport sink   (input valid, input kind, input block_number, input refill_word,
                   output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gfba_rsp_if.sv =====
// gfba_rsp_if: response channel with valid/ready handshake
`default_nettype none

interface gfba_rsp_if
   import gfba_pkg::*;
#(
   parameter int BLOCK_BITS = BLOCK_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [RESULT_W-1:0]   result_kind;
   logic [BLOCK_BITS-1:0] block_out;
   logic [BLOCK_BITS-1:0] spill_word;
   logic                  need_refill;
   logic                  last;
   logic                  modified;

   modport source (output valid, output result_kind, output block_out, output spill_word,
                   output need_refill, output last, output modified, input ready);
   modport sink   (input valid, input result_kind, input block_out, input spill_word,
                   input need_refill, input last, input modified, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/grouped_free_block_allocator.sv =====
// grouped_free_block_allocator: free block stack kept in one synchronous memory
// free, refill, refused and empty alloc transactions: response registered in the accept cycle
// alloc on a nonempty stack and free at count zero: response registered in S_POP or S_PUSH
// free on a full stack: GROUP+1 spill responses, each spill word read through the single read port
// new transactions accepted only in S_IDLE, when no response is pending or it is being taken
// reset clears count, flags and refill position; stack memory is not cleared, no sweep needed
`default_nettype none

module grouped_free_block_allocator
   import gfba_pkg::*;
#(
   parameter int GROUP      = GROUP_DEF,
   parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   gfba_req_if.sink    req_if,
   gfba_rsp_if.source  rsp_if
);

   localparam int CNT_W  = $clog2(GROUP + 1);
   localparam int ADDR_W = $clog2(GROUP);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_PUSH  = 4'b0010,
      S_POP   = 4'b0100,
      S_SPILL = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  modified_ff, modified_in;
   logic                  refill_active_ff, refill_active_in;
   logic [CNT_W-1:0]      refill_pos_ff, refill_pos_in;
   logic [ADDR_W-1:0]     spill_idx_ff, spill_idx_in;
   logic                  rd_ok_ff, rd_ok_in;
   logic [BLOCK_BITS-1:0] blk_ff, blk_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [BLOCK_BITS-1:0] rsp_block_ff, rsp_block_in;
   logic [BLOCK_BITS-1:0] rsp_spill_ff, rsp_spill_in;
   logic                  rsp_need_ff, rsp_need_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_mod_ff, rsp_mod_in;

   logic [BLOCK_BITS-1:0] mem [GROUP];
   logic [BLOCK_BITS-1:0] rd_data_ff;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [BLOCK_BITS-1:0] mem_wdata;
   logic [ADDR_W-1:0]     mem_raddr;

   logic                  slot_free;
   logic                  accept;
   logic [CNT_W-1:0]      count_m1;
   logic [CNT_W-1:0]      pos_m1;
   logic                  spill_last;

   assign slot_free  = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == S_IDLE) && slot_free;
   assign accept     = req_if.valid && req_if.ready;
   assign count_m1   = count_ff - CNT_W'(1);
   assign pos_m1     = refill_pos_ff - CNT_W'(1);
   assign spill_last = (spill_idx_ff == ADDR_W'(GROUP - 1));
   assign mem_raddr  = (state_ff == S_SPILL) ? spill_idx_ff : count_m1[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      modified_in      = modified_ff;
      refill_active_in = refill_active_ff;
      refill_pos_in    = refill_pos_ff;
      spill_idx_in     = spill_idx_ff;
      rd_ok_in         = rd_ok_ff;
      blk_in           = blk_ff;
      mem_we           = 1'b0;
      mem_waddr        = count_ff[ADDR_W-1:0];
      mem_wdata        = req_if.block_number;

      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_block_in = rsp_block_ff;
      rsp_spill_in = rsp_spill_ff;
      rsp_need_in  = rsp_need_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_mod_in   = rsp_mod_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = RES_REFUSED;
               rsp_block_in = '0;
               rsp_spill_in = '0;
               rsp_need_in  = 1'b0;
               rsp_last_in  = 1'b1;
               rsp_mod_in   = modified_ff;
               case (req_if.kind)
                  KIND_FREE: begin
                     if (!refill_active_ff) begin
                        modified_in = 1'b1;
                        rsp_mod_in  = 1'b1;
                        blk_in      = req_if.block_number;
                        if (count_ff == '0) begin
                           mem_we       = 1'b1;
                           mem_waddr    = '0;
                           mem_wdata    = '0;
                           count_in     = CNT_W'(1);
                           rsp_valid_in = 1'b0;
                           state_in     = S_PUSH;
                        end else if (count_ff >= CNT_W'(GROUP)) begin
                           rsp_kind_in  = RES_SPILL;
                           rsp_block_in = req_if.block_number;
                           rsp_spill_in = BLOCK_BITS'(GROUP);
                           rsp_last_in  = 1'b0;
                           spill_idx_in = '0;
                           rd_ok_in     = 1'b0;
                           state_in     = S_SPILL;
                        end else begin
                           mem_we      = 1'b1;
                           count_in    = count_ff + CNT_W'(1);
                           rsp_kind_in = RES_FREED;
                        end
                     end
                  end
                  KIND_ALLOC: begin
                     if (!refill_active_ff) begin
                        if (count_ff == '0) begin
                           rsp_kind_in = RES_NONE;
                        end else begin
                           rsp_valid_in = 1'b0;
                           state_in     = S_POP;
                        end
                     end
                  end
                  KIND_REFILL: begin
                     if (refill_active_ff) begin
                        rsp_kind_in = RES_REFILL;
                        if (refill_pos_ff == '0) begin
                           count_in = (req_if.refill_word > BLOCK_BITS'(GROUP)) ?
                                      CNT_W'(GROUP) : req_if.refill_word[CNT_W-1:0];
                        end else begin
                           mem_we    = 1'b1;
                           mem_waddr = pos_m1[ADDR_W-1:0];
                           mem_wdata = req_if.refill_word;
                        end
                        if (refill_pos_ff == CNT_W'(GROUP)) begin
                           refill_active_in = 1'b0;
                           refill_pos_in    = '0;
                        end else begin
                           refill_pos_in = refill_pos_ff + CNT_W'(1);
                        end
                     end
                  end
                  default: begin
                     rsp_kind_in = RES_REFUSED;
                  end
               endcase
            end
         end
         S_PUSH: begin
            mem_we       = 1'b1;
            mem_wdata    = blk_ff;
            count_in     = count_ff + CNT_W'(1);
            rsp_valid_in = 1'b1;
            rsp_kind_in  = RES_FREED;
            rsp_block_in = '0;
            rsp_spill_in = '0;
            rsp_need_in  = 1'b0;
            rsp_last_in  = 1'b1;
            rsp_mod_in   = modified_ff;
            state_in     = S_IDLE;
         end
         S_POP: begin
            rsp_valid_in = 1'b1;
            rsp_spill_in = '0;
            rsp_last_in  = 1'b1;
            rsp_need_in  = 1'b0;
            state_in     = S_IDLE;
            if (rd_data_ff == '0) begin
               count_in     = '0;
               rsp_kind_in  = RES_NONE;
               rsp_block_in = '0;
               rsp_mod_in   = modified_ff;
            end else begin
               count_in     = count_m1;
               modified_in  = 1'b1;
               rsp_kind_in  = RES_GRANTED;
               rsp_block_in = rd_data_ff;
               rsp_mod_in   = 1'b1;
               if (count_m1 == '0) begin
                  refill_active_in = 1'b1;
                  refill_pos_in    = '0;
                  rsp_need_in      = 1'b1;
               end
            end
         end
         S_SPILL: begin
            rd_ok_in = 1'b1;
            if (rd_ok_ff && slot_free) begin
               rd_ok_in     = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = RES_SPILL;
               rsp_block_in = blk_ff;
               rsp_spill_in = rd_data_ff;
               rsp_need_in  = 1'b0;
               rsp_last_in  = spill_last;
               rsp_mod_in   = 1'b1;
               if (spill_last) begin
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  mem_wdata = blk_ff;
                  count_in  = CNT_W'(1);
                  state_in  = S_IDLE;
               end else begin
                  spill_idx_in = spill_idx_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         count_ff         <= '0;
         modified_ff      <= 1'b0;
         refill_active_ff <= 1'b0;
         refill_pos_ff    <= '0;
         spill_idx_ff     <= '0;
         rd_ok_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         count_ff         <= count_in;
         modified_ff      <= modified_in;
         refill_active_ff <= refill_active_in;
         refill_pos_ff    <= refill_pos_in;
         spill_idx_ff     <= spill_idx_in;
         rd_ok_ff         <= rd_ok_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      blk_ff       <= blk_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_block_ff <= rsp_block_in;
      rsp_spill_ff <= rsp_spill_in;
      rsp_need_ff  <= rsp_need_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_mod_ff   <= rsp_mod_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.result_kind = rsp_kind_ff;
   assign rsp_if.block_out   = rsp_block_ff;
   assign rsp_if.spill_word  = rsp_spill_ff;
   assign rsp_if.need_refill = rsp_need_ff;
   assign rsp_if.last        = rsp_last_ff;
   assign rsp_if.modified    = rsp_mod_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb_grouped_free_block_allocator.sv =====
// tb_grouped_free_block_allocator: self-checking testbench for the grouped free block allocator
`timescale 1ns / 1ps

module tb_grouped_free_block_allocator;
   import gfba_pkg::*;

   localparam int GROUP   = GROUP_DEF;
   localparam int BB      = BLOCK_BITS_DEF;
   localparam int CNT_W   = 6;
   localparam int N_ITEMS = 410;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [BB-1:0]     block_number;
      logic [BB-1:0]     refill_word;
      int                n_rsp;
   } free_req_type;

   typedef struct packed {
      logic [RESULT_W-1:0] result_kind;
      logic [BB-1:0]       block_out;
      logic [BB-1:0]       spill_word;
      logic                need_refill;
      logic                is_last;
      logic                modified;
   } free_rsp_type;

   logic clock;
   logic reset;

   gfba_req_if #(.BLOCK_BITS(BB)) req_if ();
   gfba_rsp_if #(.BLOCK_BITS(BB)) rsp_if ();

   grouped_free_block_allocator #(
      .GROUP     (GROUP),
      .BLOCK_BITS(BB)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   // free list shadow state
   logic [BB-1:0]    fl_stack [GROUP];
   logic [CNT_W-1:0] fl_count;
   logic             fl_modified;
   logic             fl_refilling;
   logic [CNT_W-1:0] fl_refill_pos;

   free_req_type pending_req_q[$];
   free_rsp_type planned_rsp_q[$];
   free_rsp_type awaited_rsp_q[$];

   int mismatch_cnt;
   int accepted_cnt;
   int rsp_cnt;
   int spill_cnt;
   int grant_cnt;
   int refill_grant_cnt;
   int none_cnt;
   int refused_cnt;

   int  cur_n_rsp;
   int  send_left;
   int  gap_left;
   logic [15:0] ready_tick;
   logic        take;
   int          hold_cnt;
   logic        holding_off;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic void plan_rsp(input logic [RESULT_W-1:0] kind, input logic [BB-1:0] blk,
                                    input logic [BB-1:0] word, input logic nr,
                                    input logic lst);
      free_rsp_type r;
      r.result_kind = kind;
      r.block_out   = blk;
      r.spill_word  = word;
      r.need_refill = nr;
      r.is_last     = lst;
      r.modified    = fl_modified;
      planned_rsp_q.push_back(r);
   endfunction

   function automatic int free_list_step(input logic [KIND_W-1:0] kind,
                                         input logic [BB-1:0] blk,
                                         input logic [BB-1:0] word);
      logic [BB-1:0] popped;
      if (kind == KIND_FREE && !fl_refilling) begin
         fl_modified = 1'b1;
         if (fl_count == 0) begin
            fl_stack[0] = '0;
            fl_count    = CNT_W'(1);
         end
         if (fl_count >= GROUP) begin
            plan_rsp(RES_SPILL, blk, BB'(GROUP), 1'b0, 1'b0);
            for (int i = 0; i < GROUP; i++)
               plan_rsp(RES_SPILL, blk, fl_stack[i], 1'b0, i == GROUP - 1);
            fl_stack[0] = blk;
            fl_count    = CNT_W'(1);
            return GROUP + 1;
         end
         fl_stack[fl_count] = blk;
         fl_count           = fl_count + 1'b1;
         plan_rsp(RES_FREED, '0, '0, 1'b0, 1'b1);
         return 1;
      end
      if (kind == KIND_ALLOC && !fl_refilling) begin
         if (fl_count == 0) begin
            plan_rsp(RES_NONE, '0, '0, 1'b0, 1'b1);
            return 1;
         end
         fl_count = fl_count - 1'b1;
         popped   = fl_stack[fl_count];
         if (popped == 0) begin
            fl_count = '0;
            plan_rsp(RES_NONE, '0, '0, 1'b0, 1'b1);
            return 1;
         end
         fl_modified = 1'b1;
         if (fl_count == 0) begin
            fl_refilling  = 1'b1;
            fl_refill_pos = '0;
            plan_rsp(RES_GRANTED, popped, '0, 1'b1, 1'b1);
            return 1;
         end
         plan_rsp(RES_GRANTED, popped, '0, 1'b0, 1'b1);
         return 1;
      end
      if (kind == KIND_REFILL && fl_refilling) begin
         if (fl_refill_pos == 0)
            fl_count = (word > GROUP) ? CNT_W'(GROUP) : word[CNT_W-1:0];
         else
            fl_stack[fl_refill_pos - 1'b1] = word;
         fl_refill_pos = fl_refill_pos + 1'b1;
         if (fl_refill_pos > GROUP) begin
            fl_refilling  = 1'b0;
            fl_refill_pos = '0;
         end
         plan_rsp(RES_REFILL, '0, '0, 1'b0, 1'b1);
         return 1;
      end
      plan_rsp(RES_REFUSED, '0, '0, 1'b0, 1'b1);
      return 1;
   endfunction

   task automatic add_item(input logic [KIND_W-1:0] kind, input logic [BB-1:0] blk,
                           input logic [BB-1:0] word);
      free_req_type it;
      it.kind         = kind;
      it.block_number = blk;
      it.refill_word  = word;
      it.n_rsp        = free_list_step(kind, blk, word);
      pending_req_q.push_back(it);
   endtask

   function automatic logic [BB-1:0] rand_block();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return '1;
         default: return BB'($urandom);
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [BB-1:0] want,
                                       input logic [BB-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_cnt++;
      end
   endfunction

   // stimulus and end of run
   initial begin
      int            useful;
      int            run_left;
      logic          run_free;
      logic [BB-1:0] word;

      fl_count      = '0;
      fl_modified   = 1'b0;
      fl_refilling  = 1'b0;
      fl_refill_pos = '0;
      mismatch_cnt  = 0;

      // directed: empty list, refusals, sentinel, zero block, zero pop
      add_item(KIND_ALLOC, '0, '0);
      add_item(KIND_REFILL, '1, '1);
      add_item(KIND_UNUSED, '1, '0);
      add_item(KIND_FREE, '1, '0);
      add_item(KIND_FREE, '0, '1);
      add_item(KIND_FREE, BB'(1), '0);
      add_item(KIND_ALLOC, '1, '1);
      add_item(KIND_ALLOC, '0, '0);
      add_item(KIND_ALLOC, '0, '0);
      add_item(KIND_FREE, BB'(24'h800000), BB'(24'h7FFFFF));
      add_item(KIND_ALLOC, '0, '0);
      add_item(KIND_ALLOC, '0, '0);
      add_item(KIND_FREE, BB'(24'h555555), BB'(24'hAAAAAA));
      add_item(KIND_FREE, BB'(24'hAAAAAA), BB'(24'h555555));

      // random: alternating free and alloc runs, refills when asked for
      useful   = 0;
      run_free = 1'b1;
      run_left = GROUP + 2;
      while (useful < N_ITEMS) begin
         if (fl_refilling) begin
            if ($urandom_range(0, 19) == 0) begin
               case ($urandom_range(0, 2))
                  0:       add_item(KIND_FREE, rand_block(), BB'($urandom));
                  1:       add_item(KIND_ALLOC, BB'($urandom), BB'($urandom));
                  default: add_item(KIND_UNUSED, BB'($urandom), BB'($urandom));
               endcase
            end else begin
               if (fl_refill_pos == 0) begin
                  case ($urandom_range(0, 5))
                     0:       word = '0;
                     1:       word = BB'(GROUP);
                     2:       word = ($urandom_range(0, 1) == 0) ? '1 :
                                     BB'($urandom_range(GROUP + 1, (1 << BB) - 1));
                     default: word = BB'($urandom_range(1, GROUP));
                  endcase
               end else begin
                  word = rand_block();
               end
               add_item(KIND_REFILL, BB'($urandom), word);
               useful++;
            end
         end else begin
            if (run_left == 0) begin
               run_free = !run_free;
               run_left = run_free ? $urandom_range(1, 40) : $urandom_range(1, 30);
            end
            run_left--;
            if ($urandom_range(0, 19) == 0) begin
               add_item(($urandom_range(0, 1) == 0) ? KIND_UNUSED : KIND_REFILL,
                        BB'($urandom), BB'($urandom));
            end else begin
               add_item(run_free ? KIND_FREE : KIND_ALLOC, rand_block(), BB'($urandom));
               useful++;
            end
         end
      end

      while (reset) @(posedge clock);
      while (pending_req_q.size() != 0 || req_if.valid) @(posedge clock);
      while (awaited_rsp_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (awaited_rsp_q.size() != 0 || planned_rsp_q.size() != 0) begin
         $error("%0d results still outstanding",
                awaited_rsp_q.size() + planned_rsp_q.size());
         mismatch_cnt++;
      end

      $display("%0d transactions in, %0d results out, %0d mismatches", accepted_cnt,
               rsp_cnt, mismatch_cnt);
      $display("%0d spill words, %0d grants (%0d asking refill), %0d none left, %0d refused",
               spill_cnt, grant_cnt, refill_grant_cnt, none_cnt, refused_cnt);
      if (mismatch_cnt == 0) begin
         $display("[grouped_free_block_allocator] OK");
      end else begin
         $display("[grouped_free_block_allocator] ERROR");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("[grouped_free_block_allocator] ERROR");
      $finish;
   end

   // request driver: bursts with random gaps
   initial begin
      accepted_cnt = 0;
      cur_n_rsp    = 0;
      send_left    = 8;
      gap_left     = 0;
   end

   always @(posedge clock) begin
      free_req_type it;
      if (reset) begin
         req_if.valid        <= 1'b0;
         req_if.kind         <= KIND_FREE;
         req_if.block_number <= '0;
         req_if.refill_word  <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            for (int k = 0; k < cur_n_rsp; k++)
               awaited_rsp_q.push_back(planned_rsp_q.pop_front());
            accepted_cnt++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0 || pending_req_q.size() == 0) begin
               req_if.valid <= 1'b0;
               if (gap_left > 0)
                  gap_left--;
            end else begin
               it = pending_req_q.pop_front();
               req_if.valid        <= 1'b1;
               req_if.kind         <= it.kind;
               req_if.block_number <= it.block_number;
               req_if.refill_word  <= it.refill_word;
               cur_n_rsp = it.n_rsp;
               send_left--;
               if (send_left <= 0) begin
                  send_left = $urandom_range(1, 24);
                  gap_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // long receiver hold-off so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt    <= 0;
         holding_off <= 1'b0;
      end else begin
         hold_cnt    <= hold_cnt + 1;
         holding_off <= (hold_cnt >= 300 && hold_cnt < 700);
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         ready_tick   <= '0;
      end else begin
         ready_tick <= ready_tick + 1'b1;
         case (ready_tick[9:8])
            2'd0:    take = 1'b1;
            2'd1:    take = ($urandom_range(0, 3) != 0);
            2'd2:    take = (ready_tick[1:0] == 2'd0);
            default: take = ($urandom_range(0, 1) == 1);
         endcase
         rsp_if.ready <= take && !holding_off;
      end
   end

   // result monitor
   initial begin
      rsp_cnt          = 0;
      spill_cnt        = 0;
      grant_cnt        = 0;
      refill_grant_cnt = 0;
      none_cnt         = 0;
      refused_cnt      = 0;
   end

   always @(posedge clock) begin
      free_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         rsp_cnt++;
         if (awaited_rsp_q.size() == 0) begin
            $error("result with nothing awaited: result_kind %0d, block_out 0x%0h",
                   rsp_if.result_kind, rsp_if.block_out);
            mismatch_cnt++;
         end else begin
            want = awaited_rsp_q.pop_front();
            check_field("result_kind", BB'(want.result_kind), BB'(rsp_if.result_kind));
            check_field("block_out", want.block_out, rsp_if.block_out);
            check_field("spill_word", want.spill_word, rsp_if.spill_word);
            check_field("need_refill", BB'(want.need_refill), BB'(rsp_if.need_refill));
            check_field("last", BB'(want.is_last), BB'(rsp_if.last));
            check_field("modified", BB'(want.modified), BB'(rsp_if.modified));
            case (want.result_kind)
               RES_SPILL:   spill_cnt++;
               RES_GRANTED: begin
                  grant_cnt++;
                  if (want.need_refill)
                     refill_grant_cnt++;
               end
               RES_NONE:    none_cnt++;
               RES_REFUSED: refused_cnt++;
               default:     ;
            endcase
         end
      end
   end

endmodule
